>>> rtl/btmx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btmx_pkg
// Shared codes and field widths of the binary trie maximum-xor block.
// ----------------------------------------------------------------------------
package btmx_pkg;

  localparam int KEY_W    = 41;
  localparam int STATUS_W = 2;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

endpackage

>>> rtl/binary_trie_max_xor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_trie_max_xor
// Bitwise trie of keys in a node memory: insert keys, query the maximum xor.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready) carries an opcode and a key. Opcode
//   insert adds the key, opcode query returns the largest xor of the key with
//   any stored key. Each item gives exactly one result on the out_ channel
//   (out_valid/out_ready) with max_xor and a status: ok, pool full (insert
//   left undone) or empty trie (query before any insert).
//   Items are handled one at a time. A walk makes one node memory access per
//   key level, so an item walks every key level from transfer to result
//   register, stopping sooner for a query whose path ends early; an item
//   answered from the status checks alone skips the walk. The next
//   item is taken in the cycle after the result is registered.
//   The node memory is never cleared: an empty-trie flag stands in for the
//   root until the first insert, and every allocated inner node is written
//   whole when it is created.
//   Reset (synchronous, active low) empties the trie and frees the pool.
//   A stalled receiver holds the result in the output register; a finished
//   walk then waits for the register before accepting a new item.
// ----------------------------------------------------------------------------
module binary_trie_max_xor #(
  parameter int KEY_BITS   = 41,
  parameter int NODE_COUNT = 65536
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_opcode,
  input  btmx_pkg::key_t           in_key,
  output logic                     out_valid,
  input  logic                     out_ready,
  output btmx_pkg::key_t           out_max_xor,
  output btmx_pkg::status_t        out_status
);

  localparam int NODE_W  = $clog2(NODE_COUNT);
  localparam int CNT_W   = $clog2(NODE_COUNT + 1);
  localparam int POS_W   = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int ENTRY_W = 2 * NODE_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_NEW = 3'd2;
  localparam logic [2:0] S_Q_RD    = 3'd3;
  localparam logic [2:0] S_DONE    = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [NODE_W-1:0]       node_r, node_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    empty_r, empty_nxt;
  logic [KEY_BITS-1:0]     key_r, key_nxt;
  logic [KEY_BITS-1:0]     acc_r, acc_nxt;
  btmx_pkg::status_t       res_status_r, res_status_nxt;
  logic                    out_valid_r, out_valid_nxt;
  btmx_pkg::key_t          out_max_xor_r, out_max_xor_nxt;
  btmx_pkg::status_t       out_status_r, out_status_nxt;

  logic                    ram_we;
  logic [NODE_W-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]      ram_wdata;
  logic [NODE_W-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]      ram_rdata;

  logic                    cur_bit;
  logic [NODE_W-1:0]       link0, link1, link_same, link_opp, link_q;
  logic [NODE_W-1:0]       cnt_node;
  logic [CNT_W-1:0]        free_nodes;
  logic                    pool_full;
  logic                    pos_last;

  btmx_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODE_COUNT)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cur_bit    = key_r[pos_r];
  assign link0      = ram_rdata[NODE_W-1:0];
  assign link1      = ram_rdata[ENTRY_W-1:NODE_W];
  assign link_same  = cur_bit ? link1 : link0;
  assign link_opp   = cur_bit ? link0 : link1;
  assign link_q     = (link_opp != '0) ? link_opp : link_same;
  assign cnt_node   = cnt_r[NODE_W-1:0];
  assign free_nodes = CNT_W'(NODE_COUNT) - cnt_r;
  assign pool_full  = free_nodes < CNT_W'(KEY_BITS);
  assign pos_last   = (pos_r == '0);

  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    node_nxt        = node_r;
    cnt_nxt         = cnt_r;
    empty_nxt       = empty_r;
    key_nxt         = key_r;
    acc_nxt         = acc_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_max_xor_nxt = out_max_xor_r;
    out_status_nxt  = out_status_r;
    ram_we          = 1'b0;
    ram_waddr       = node_r;
    ram_wdata       = '0;
    ram_raddr       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt        = KEY_BITS'(in_key);
          pos_nxt        = POS_W'(KEY_BITS - 1);
          node_nxt       = '0;
          acc_nxt        = '0;
          res_status_nxt = btmx_pkg::ST_OK;
          if (in_opcode == btmx_pkg::OP_INSERT) begin
            if (pool_full) begin
              res_status_nxt = btmx_pkg::ST_FULL;
              state_nxt      = S_DONE;
            end else if (empty_r) begin
              // root links are undefined until the first insert writes them
              state_nxt = S_INS_NEW;
            end else begin
              state_nxt = S_INS_RD;
            end
          end else begin
            if (empty_r) begin
              res_status_nxt = btmx_pkg::ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_Q_RD;
            end
          end
        end
      end
      S_INS_RD: begin
        if (link_same != '0) begin
          node_nxt = link_same;
          if (pos_last) begin
            empty_nxt = 1'b0;
            state_nxt = S_DONE;
          end else begin
            ram_raddr = link_same;
            pos_nxt   = pos_r - 1'b1;
          end
        end else begin
          // first missing child: keep the sibling link, point at a fresh node
          ram_we    = 1'b1;
          ram_wdata = cur_bit ? {cnt_node, link0} : {link1, cnt_node};
          node_nxt  = cnt_node;
          cnt_nxt   = cnt_r + 1'b1;
          if (pos_last) begin
            empty_nxt = 1'b0;
            state_nxt = S_DONE;
          end else begin
            pos_nxt   = pos_r - 1'b1;
            state_nxt = S_INS_NEW;
          end
        end
      end
      S_INS_NEW: begin
        // node is fresh, so its other link is empty and nothing needs reading
        ram_we    = 1'b1;
        ram_wdata = cur_bit ? {cnt_node, {NODE_W{1'b0}}} : {{NODE_W{1'b0}}, cnt_node};
        node_nxt  = cnt_node;
        cnt_nxt   = cnt_r + 1'b1;
        if (pos_last) begin
          empty_nxt = 1'b0;
          state_nxt = S_DONE;
        end else begin
          pos_nxt = pos_r - 1'b1;
        end
      end
      S_Q_RD: begin
        if (link_opp != '0) begin
          acc_nxt = acc_r | (KEY_BITS'(1) << pos_r);
        end
        node_nxt = link_q;
        if (link_q == '0 || pos_last) begin
          state_nxt = S_DONE;
        end else begin
          ram_raddr = link_q;
          pos_nxt   = pos_r - 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_max_xor_nxt = btmx_pkg::KEY_W'(acc_r);
          out_status_nxt  = res_status_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= CNT_W'(1);
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r         <= pos_nxt;
    node_r        <= node_nxt;
    key_r         <= key_nxt;
    acc_r         <= acc_nxt;
    res_status_r  <= res_status_nxt;
    out_max_xor_r <= out_max_xor_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_max_xor = out_max_xor_r;
  assign out_status  = out_status_r;

  // the pool never hands out more nodes than the memory holds
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NODE_COUNT))
    else $error("node count beyond pool size");

  // only allocated nodes are ever written
  a_write_allocated: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (CNT_W'(ram_waddr) < cnt_r))
    else $error("write to an unallocated node");

  // the trie stops being empty only at the end of an insert walk
  a_empty_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(empty_r) |-> ($past(state_r) == S_INS_RD || $past(state_r) == S_INS_NEW))
    else $error("empty flag cleared outside an insert");

endmodule

>>> rtl/btmx_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btmx_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module btmx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> dv/binary_trie_max_xor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_trie_max_xor_tb
// Self-checking bench for the trie maximum-xor block: a local trie predicts
// every answer. Directed keys come first, then a random insert/query mix.
// An insert-heavy phase of fresh keys then grows the trie deep into the node
// pool. Sender bursts, receiver stalls and two long receiver hold-offs
// move the gaps across every point of the walk.
// ----------------------------------------------------------------------------
module binary_trie_max_xor_tb;

  localparam int TRIE_NODES   = 65536;
  localparam int MIX_ITEMS    = 500;
  localparam int FILL_ROUNDS  = 20;
  localparam int TAIL_ITEMS   = 120;
  localparam int LONG_HOLD    = 600;
  localparam int HOLD_AT_A    = 3000;
  localparam int HOLD_AT_B    = 40000;
  localparam int SETTLE_CYC   = 60;
  localparam longint RUN_LIMIT_NS = 64'd20_000_000;

  typedef struct packed {
    logic           opcode;
    btmx_pkg::key_t key;
  } trie_op_t;

  typedef struct packed {
    btmx_pkg::key_t    max_xor;
    btmx_pkg::status_t status;
  } answer_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_opcode = btmx_pkg::OP_INSERT;
  btmx_pkg::key_t    in_key = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  btmx_pkg::key_t    out_max_xor;
  btmx_pkg::status_t out_status;

  binary_trie_max_xor #(
    .KEY_BITS   (btmx_pkg::KEY_W),
    .NODE_COUNT (TRIE_NODES)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_key      (in_key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_max_xor (out_max_xor),
    .out_status  (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  // local copy of the trie; 0 in a link means no child
  int unsigned kid_link [TRIE_NODES][2];
  int          nodes_taken = 1;
  bit          has_keys = 1'b0;
  int          n_insert = 0;
  int          n_query = 0;
  int          n_full = 0;
  int          n_empty = 0;

  trie_op_t       ops_pending [$];
  answer_t        answers_due [$];
  btmx_pkg::key_t issued_keys [$];
  int             errors = 0;

  function automatic answer_t trie_apply(input logic op, input btmx_pkg::key_t key);
    answer_t     ans;
    int unsigned node;
    int unsigned nxt;
    int unsigned opp;
    int          lvl;
    int          b;
    ans.max_xor = '0;
    ans.status  = btmx_pkg::ST_OK;
    node = 0;
    if (op == btmx_pkg::OP_INSERT) begin
      n_insert++;
      if (TRIE_NODES - nodes_taken < btmx_pkg::KEY_W) begin
        ans.status = btmx_pkg::ST_FULL;
        n_full++;
      end else begin
        for (lvl = btmx_pkg::KEY_W - 1; lvl >= 0; lvl--) begin
          b = int'(key[lvl]);
          nxt = kid_link[node][b];
          if (nxt == 0) begin
            nxt = nodes_taken;
            nodes_taken++;
            kid_link[nxt][0] = 0;
            kid_link[nxt][1] = 0;
            kid_link[node][b] = nxt;
          end
          node = nxt;
        end
        has_keys = 1'b1;
      end
    end else begin
      n_query++;
      if (!has_keys) begin
        ans.status = btmx_pkg::ST_EMPTY;
        n_empty++;
      end else begin
        for (lvl = btmx_pkg::KEY_W - 1; lvl >= 0; lvl--) begin
          b = int'(key[lvl]);
          opp = kid_link[node][1 - b];
          if (opp != 0) begin
            ans.max_xor[lvl] = 1'b1;
            nxt = opp;
          end else begin
            nxt = kid_link[node][b];
          end
          // a broken path keeps the bits found so far
          if (nxt == 0 || nxt >= TRIE_NODES) break;
          node = nxt;
        end
      end
    end
    return ans;
  endfunction

  function automatic btmx_pkg::key_t full_rand_key();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[btmx_pkg::KEY_W-1:0];
  endfunction

  function automatic btmx_pkg::key_t mixed_key();
    btmx_pkg::key_t k;
    btmx_pkg::key_t seen;
    k = full_rand_key();
    if (issued_keys.size() != 0) seen = issued_keys[$urandom_range(issued_keys.size() - 1)];
    else seen = k;
    case ($urandom_range(9))
      5:       k = btmx_pkg::key_t'($urandom_range(255));
      6:       k = seen;
      7:       k = seen ^ btmx_pkg::key_t'($urandom_range(255));
      8:       k = seen ^ (btmx_pkg::key_t'(1) << $urandom_range(btmx_pkg::KEY_W - 1));
      9:       k = $urandom_range(1) ? '1 : '0;
      default: ;
    endcase
    return k;
  endfunction

  task automatic queue_op(input logic op, input btmx_pkg::key_t key);
    ops_pending.push_back('{opcode: op, key: key});
    if (op == btmx_pkg::OP_INSERT) issued_keys.push_back(key);
  endtask

  // sender: bursts of random length, random gaps in between
  int tx_burst = 1;
  int tx_gap = 0;

  always @(posedge clk) begin
    trie_op_t nxt_op;
    if (rst_n) begin
      if (in_valid && in_ready) answers_due.push_back(trie_apply(in_opcode, in_key));
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (ops_pending.size() != 0) begin
          nxt_op = ops_pending.pop_front();
          in_valid <= 1'b1;
          in_opcode <= nxt_op.opcode;
          in_key <= nxt_op.key;
          if (tx_burst <= 1) begin
            tx_burst <= $urandom_range(24, 1);
            case ($urandom_range(4))
              0, 1:    tx_gap <= 0;
              2, 3:    tx_gap <= $urandom_range(10, 1);
              default: tx_gap <= $urandom_range(60, 20);
            endcase
          end else begin
            tx_burst <= tx_burst - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, calm stretches, and a long hold-off twice
  int rx_cycles = 0;
  int rx_hold = 0;

  always @(posedge clk) begin
    int hold;
    if (rx_cycles == HOLD_AT_A || rx_cycles == HOLD_AT_B) hold = LONG_HOLD;
    else if (rx_hold > 0) hold = rx_hold - 1;
    else if (rx_cycles[11]) hold = 0;
    else if ($urandom_range(99) < 25) hold = $urandom_range(40, 1);
    else hold = 0;
    rx_hold <= hold;
    rx_cycles <= rx_cycles + 1;
    out_ready <= (hold == 0);
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid && out_ready) begin
      if (answers_due.size() == 0) begin
        $error("unexpected transfer: max_xor %h status %0d", out_max_xor, out_status);
        errors++;
      end else begin
        want = answers_due.pop_front();
        if (out_max_xor !== want.max_xor) begin
          $error("max_xor mismatch: expected %h, got %h", want.max_xor, out_max_xor);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [63:0]    stripes;
    btmx_pkg::key_t alt_a;
    btmx_pkg::key_t alt_b;
    btmx_pkg::key_t top_bit;
    btmx_pkg::key_t one_key;
    int             rounds;
    int             i;
    stripes = 64'h5555_5555_5555_5555;
    alt_a = stripes[btmx_pkg::KEY_W-1:0];
    alt_b = ~alt_a;
    one_key = btmx_pkg::key_t'(1);
    top_bit = one_key << (btmx_pkg::KEY_W - 1);

    // queries before any insert see an empty trie
    queue_op(btmx_pkg::OP_QUERY, '0);
    queue_op(btmx_pkg::OP_QUERY, '1);
    queue_op(btmx_pkg::OP_INSERT, '0);
    queue_op(btmx_pkg::OP_QUERY, '0);
    queue_op(btmx_pkg::OP_QUERY, '1);
    queue_op(btmx_pkg::OP_INSERT, '0);
    queue_op(btmx_pkg::OP_INSERT, '1);
    queue_op(btmx_pkg::OP_QUERY, '0);
    queue_op(btmx_pkg::OP_QUERY, alt_a);
    queue_op(btmx_pkg::OP_INSERT, alt_a);
    queue_op(btmx_pkg::OP_INSERT, alt_b);
    queue_op(btmx_pkg::OP_QUERY, alt_a);
    queue_op(btmx_pkg::OP_QUERY, alt_b);
    queue_op(btmx_pkg::OP_INSERT, top_bit);
    queue_op(btmx_pkg::OP_INSERT, one_key);
    queue_op(btmx_pkg::OP_QUERY, top_bit);
    queue_op(btmx_pkg::OP_QUERY, one_key);
    queue_op(btmx_pkg::OP_INSERT, alt_a);
    queue_op(btmx_pkg::OP_QUERY, top_bit ^ one_key);
    queue_op(btmx_pkg::OP_QUERY, full_rand_key());

    for (i = 0; i < MIX_ITEMS; i++) begin
      queue_op(($urandom_range(99) < 55) ? btmx_pkg::OP_INSERT : btmx_pkg::OP_QUERY,
               mixed_key());
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // mostly fresh keys to grow the trie, stopping early should the pool run out
    rounds = 0;
    while (n_full == 0 && rounds < FILL_ROUNDS) begin
      while (ops_pending.size() > 8) @(posedge clk);
      for (i = 0; i < 40; i++) begin
        if ($urandom_range(9) == 0) queue_op(btmx_pkg::OP_QUERY, mixed_key());
        else queue_op(btmx_pkg::OP_INSERT, full_rand_key());
      end
      rounds++;
    end

    for (i = 0; i < TAIL_ITEMS; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: queue_op(btmx_pkg::OP_QUERY, mixed_key());
        4, 5, 6:    queue_op(btmx_pkg::OP_INSERT,
                             issued_keys[$urandom_range(issued_keys.size() - 1)]);
        default:    queue_op(btmx_pkg::OP_INSERT, full_rand_key());
      endcase
    end

    while (ops_pending.size() != 0 || in_valid) @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (answers_due.size() != 0) begin
      $error("%0d expected results never arrived", answers_due.size());
      errors++;
    end

    $display("covered %0d inserts and %0d queries, %0d nodes in use", n_insert, n_query,
             nodes_taken);
    $display("%0d inserts refused on a full pool, %0d queries on an empty trie", n_full,
             n_empty);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
